// ===== src/vsjb_pkg.sv =====
// ---------------------------------------------------------------------------
// Voice slot jitter buffer package
// Shared widths, item kind codes, register indexes and the compare result
// type of the timestamp unit.
// ---------------------------------------------------------------------------
package vsjb_pkg;

  localparam int KIND_W    = 2;
  localparam int ID_W      = 8;
  localparam int SMP_W     = 16;
  localparam int VOICE_W   = 4;
  localparam int SLOT_W    = 3;
  localparam int FILL_W    = 11;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [KIND_W-1:0] KIND_HDR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_HOLD = 1'd1;

  localparam logic [CFG_W-1:0] IDLE_TIMEOUT_RST = 16'd100;
  localparam logic [CFG_W-1:0] RELEASE_HOLD_RST = 16'd250;

  typedef struct packed {
    logic neg;      // a - b is negative in wrap-aware terms
    logic gt_idle;  // a - b above the idle timeout
    logic lt_idle;  // a - b below the idle timeout
    logic lt_hold;  // a - b below the release hold
  } age_cmp_t;

endpackage

// ===== src/vsjb_if.sv =====
// ---------------------------------------------------------------------------
// Voice slot jitter buffer channels
// Input item channel and result channel, each a valid/ready beat carrier.
// ---------------------------------------------------------------------------
interface vsjb_in_if;
  import vsjb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [ID_W-1:0]          wire_id;
  logic                     gate;
  logic signed [SMP_W-1:0]  sample;
  logic [VOICE_W-1:0]       voice;

  modport source (output valid, kind, wire_id, gate, sample, voice, input ready);
  modport sink   (input valid, kind, wire_id, gate, sample, voice, output ready);
endinterface

interface vsjb_out_if;
  import vsjb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     accepted;
  logic [SLOT_W-1:0]        slot;
  logic                     dropped_oldest;
  logic                     read_valid;
  logic signed [SMP_W-1:0]  read_sample;
  logic                     in_use;
  logic                     gate_active;
  logic [FILL_W-1:0]        fill;

  modport source (output valid, accepted, slot, dropped_oldest, read_valid, read_sample,
                  in_use, gate_active, fill, input ready);
  modport sink   (input valid, accepted, slot, dropped_oldest, read_valid, read_sample,
                  in_use, gate_active, fill, output ready);
endinterface

// ===== src/vsjb_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module vsjb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/vsjb_age_unit.sv =====
// ---------------------------------------------------------------------------
// Timestamp compare unit
// Shared 32-bit subtractor with compares against the two time limits.
// ---------------------------------------------------------------------------
module vsjb_age_unit (
  input  logic [vsjb_pkg::TIME_W-1:0] a_i,
  input  logic [vsjb_pkg::TIME_W-1:0] b_i,
  input  logic [vsjb_pkg::CFG_W-1:0]  idle_i,
  input  logic [vsjb_pkg::CFG_W-1:0]  hold_i,
  output vsjb_pkg::age_cmp_t          cmp_o
);
  import vsjb_pkg::*;

  logic [TIME_W-1:0] diff;
  logic [TIME_W-1:0] idle_x;
  logic [TIME_W-1:0] hold_x;

  assign diff   = a_i - b_i;
  assign idle_x = TIME_W'(idle_i);
  assign hold_x = TIME_W'(hold_i);

  assign cmp_o.neg     = diff[TIME_W-1];
  assign cmp_o.gt_idle = diff > idle_x;
  assign cmp_o.lt_idle = diff < idle_x;
  assign cmp_o.lt_hold = diff < hold_x;

endmodule

// ===== src/voice_slot_jitter_buffer.sv =====
// ---------------------------------------------------------------------------
// Voice slot jitter buffer
// Binds stream ids to voice slots and keeps one sample ring per slot.
// ---------------------------------------------------------------------------
// Items enter on in_i and each gives exactly one result beat on out_o.
// A header binds its stream to a slot (existing binding, first free slot,
// or the oldest slot if idle past idle_timeout_ms); a push stores a sample
// in the slot of the last good header; a read pops one sample of a named
// slot with its status; a tick advances the millisecond counter.
// The block takes one item at a time. A header scans the slots, runs the
// steal check if none matched, then binds or fails; a push runs the push
// state; a read runs pop and status (not for a slot out of range); each
// item ends in done, which loads the result register. The scan visits
// one slot per cycle on the shared timestamp subtractor; a match ends it.
// Ring data lives in a single RAM shared by all slots, one port each way.
// Reset clears all slot bindings, ring pointers and time at once; the RAM
// holds no reset state. If the receiver stalls, the result stays in the
// output register; one more item is still taken and worked on, and its
// result waits in the last state until the output register frees.
// Configuration must be written through cfg_we_i while the block is idle (unchecked).
// ---------------------------------------------------------------------------
module voice_slot_jitter_buffer #(
  parameter int VOICES     = 8,
  parameter int FIFO_DEPTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vsjb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [vsjb_pkg::CFG_W-1:0]     cfg_data_i,
  vsjb_in_if.sink                        in_i,
  vsjb_out_if.source                     out_o
);
  import vsjb_pkg::*;

  localparam int SW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int IW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int AW = SW + IW;

  localparam logic [CW-1:0] FULL_CNT  = CW'(FIFO_DEPTH);
  localparam logic [SW-1:0] LAST_SLOT = SW'(VOICES - 1);
  localparam logic [IW:0]   DEPTH_X   = (IW + 1)'(FIFO_DEPTH);
  localparam logic [IW-1:0] LAST_IDX  = IW'(FIFO_DEPTH - 1);
  localparam logic [VOICE_W:0] VOICES_X = (VOICE_W + 1)'(VOICES);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_STEAL = 3'd2;
  localparam logic [2:0] ST_BIND  = 3'd3;
  localparam logic [2:0] ST_PUSH  = 3'd4;
  localparam logic [2:0] ST_POP   = 3'd5;
  localparam logic [2:0] ST_STAT  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  // Configuration registers.
  logic [CFG_W-1:0] idle_q, hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q <= IDLE_TIMEOUT_RST;
      hold_q <= RELEASE_HOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDLE_TIMEOUT: idle_q <= cfg_data_i;
        CFG_RELEASE_HOLD: hold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Per-slot state, always accessed at the slot pointer sel_q.
  logic [VOICES-1:0] bound_q;
  logic [ID_W-1:0]   id_q    [VOICES];
  logic [VOICES-1:0] gate_q;
  logic [TIME_W-1:0] last_q  [VOICES];
  logic [IW-1:0]     head_q  [VOICES];
  logic [CW-1:0]     count_q [VOICES];

  logic [2:0]          state_q, state_d;
  logic [SW-1:0]       sel_q, sel_d;
  logic [TIME_W-1:0]   time_q, time_d;
  logic [SW-1:0]       cur_slot_q, cur_slot_d;
  logic                cur_valid_q, cur_valid_d;
  logic [ID_W-1:0]     wid_q, wid_d;
  logic                hgate_q, hgate_d;
  logic [SMP_W-1:0]    smp_q, smp_d;
  logic                have_free_q, have_free_d;
  logic [SW-1:0]       free_idx_q, free_idx_d;
  logic                have_old_q, have_old_d;
  logic [SW-1:0]       old_idx_q, old_idx_d;
  logic [TIME_W-1:0]   old_last_q, old_last_d;
  logic                new_q, new_d;
  logic                popped_q, popped_d;

  logic                res_acc_q, res_acc_d;
  logic [SLOT_W-1:0]   res_slot_q, res_slot_d;
  logic                res_drop_q, res_drop_d;
  logic                res_rvld_q, res_rvld_d;
  logic [SMP_W-1:0]    res_smp_q, res_smp_d;
  logic                res_use_q, res_use_d;
  logic                res_gate_q, res_gate_d;
  logic [FILL_W-1:0]   res_fill_q, res_fill_d;

  logic                out_valid_q, out_valid_d;
  logic                out_load;
  logic                out_acc_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic                out_drop_q;
  logic                out_rvld_q;
  logic [SMP_W-1:0]    out_smp_q;
  logic                out_use_q;
  logic                out_gate_q;
  logic [FILL_W-1:0]   out_fill_q;

  logic                bind_we, ring_we;
  logic [IW-1:0]       head_d;
  logic [CW-1:0]       count_d;

  logic                bound_r, gate_r;
  logic [ID_W-1:0]     id_r;
  logic [TIME_W-1:0]   last_r;
  logic [IW-1:0]       head_r;
  logic [CW-1:0]       count_r;

  logic [IW:0]         sum_pos;
  logic [IW-1:0]       wr_pos, head_inc;
  logic [VOICE_W-1:0]  sel_wide;

  logic [TIME_W-1:0]   op_a, op_b;
  age_cmp_t            cmp;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [SMP_W-1:0]    ram_rdata;

  assign bound_r = bound_q[sel_q];
  assign gate_r  = gate_q[sel_q];
  assign id_r    = id_q[sel_q];
  assign last_r  = last_q[sel_q];
  assign head_r  = head_q[sel_q];
  assign count_r = count_q[sel_q];

  // Write position of a ring that is not full: head plus count stays below
  // twice the depth, so one conditional subtract wraps it.
  assign sum_pos  = {1'b0, head_r} + (IW + 1)'(count_r);
  assign wr_pos   = (sum_pos >= DEPTH_X) ? IW'(sum_pos - DEPTH_X) : sum_pos[IW-1:0];
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign sel_wide = VOICE_W'(sel_q);

  vsjb_age_unit u_age (
    .a_i    (op_a),
    .b_i    (op_b),
    .idle_i (idle_q),
    .hold_i (hold_q),
    .cmp_o  (cmp)
  );

  vsjb_ram #(
    .WIDTH (SMP_W),
    .DEPTH (1 << AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (smp_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    time_d      = time_q;
    cur_slot_d  = cur_slot_q;
    cur_valid_d = cur_valid_q;
    wid_d       = wid_q;
    hgate_d     = hgate_q;
    smp_d       = smp_q;
    have_free_d = have_free_q;
    free_idx_d  = free_idx_q;
    have_old_d  = have_old_q;
    old_idx_d   = old_idx_q;
    old_last_d  = old_last_q;
    new_d       = new_q;
    popped_d    = popped_q;
    res_acc_d   = res_acc_q;
    res_slot_d  = res_slot_q;
    res_drop_d  = res_drop_q;
    res_rvld_d  = res_rvld_q;
    res_smp_d   = res_smp_q;
    res_use_d   = res_use_q;
    res_gate_d  = res_gate_q;
    res_fill_d  = res_fill_q;
    bind_we     = 1'b0;
    ring_we     = 1'b0;
    head_d      = head_r;
    count_d     = count_r;
    ram_we      = 1'b0;
    ram_waddr   = {sel_q, head_r};
    ram_raddr   = {sel_q, head_r};
    op_a        = time_q;
    op_b        = last_r;
    out_load    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          wid_d      = in_i.wire_id;
          hgate_d    = in_i.gate;
          smp_d      = in_i.sample;
          res_acc_d  = 1'b0;
          res_slot_d = '0;
          res_drop_d = 1'b0;
          res_rvld_d = 1'b0;
          res_smp_d  = '0;
          res_use_d  = 1'b0;
          res_gate_d = 1'b0;
          res_fill_d = '0;
          case (in_i.kind)
            KIND_HDR: begin
              sel_d       = '0;
              have_free_d = 1'b0;
              have_old_d  = 1'b0;
              state_d     = ST_SCAN;
            end
            KIND_PUSH: begin
              sel_d   = cur_slot_q;
              state_d = ST_PUSH;
            end
            KIND_READ: begin
              if ({1'b0, in_i.voice} < VOICES_X) begin
                sel_d   = in_i.voice[SW-1:0];
                state_d = ST_POP;
              end else begin
                state_d = ST_DONE;
              end
            end
            KIND_TICK: begin
              time_d  = time_q + 1'b1;
              state_d = ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      ST_SCAN: begin
        op_a = last_r;
        op_b = old_last_q;
        if (bound_r && (id_r == wid_q)) begin
          new_d   = 1'b0;
          state_d = ST_BIND;
        end else begin
          if (!bound_r) begin
            if (!have_free_q) begin
              have_free_d = 1'b1;
              free_idx_d  = sel_q;
            end
          end else if (!have_old_q || cmp.neg) begin
            have_old_d = 1'b1;
            old_idx_d  = sel_q;
            old_last_d = last_r;
          end
          if (sel_q == LAST_SLOT) begin
            state_d = ST_STEAL;
          end else begin
            sel_d = sel_q + 1'b1;
          end
        end
      end

      ST_STEAL: begin
        op_a = time_q;
        op_b = old_last_q;
        if (have_free_q) begin
          sel_d   = free_idx_q;
          new_d   = 1'b1;
          state_d = ST_BIND;
        end else if (have_old_q && cmp.gt_idle) begin
          sel_d   = old_idx_q;
          new_d   = 1'b1;
          state_d = ST_BIND;
        end else begin
          cur_valid_d = 1'b0;
          state_d     = ST_DONE;
        end
      end

      ST_BIND: begin
        bind_we     = 1'b1;
        cur_slot_d  = sel_q;
        cur_valid_d = 1'b1;
        res_acc_d   = 1'b1;
        res_slot_d  = sel_wide[SLOT_W-1:0];
        state_d     = ST_DONE;
      end

      ST_PUSH: begin
        if (cur_valid_q && bound_r) begin
          ram_we    = 1'b1;
          ring_we   = 1'b1;
          res_acc_d = 1'b1;
          if (count_r == FULL_CNT) begin
            // Full ring: the new sample takes the oldest one's place.
            ram_waddr  = {sel_q, head_r};
            head_d     = head_inc;
            res_drop_d = 1'b1;
          end else begin
            ram_waddr = {sel_q, wr_pos};
            count_d   = count_r + 1'b1;
          end
        end
        state_d = ST_DONE;
      end

      ST_POP: begin
        popped_d = 1'b0;
        if (count_r != '0) begin
          popped_d = 1'b1;
          ring_we  = 1'b1;
          head_d   = head_inc;
          count_d  = count_r - 1'b1;
        end
        state_d = ST_STAT;
      end

      ST_STAT: begin
        op_a       = time_q;
        op_b       = last_r;
        res_rvld_d = popped_q;
        res_smp_d  = popped_q ? ram_rdata : '0;
        res_use_d  = bound_r && (cmp.lt_hold || (count_r != '0));
        res_gate_d = bound_r && gate_r && cmp.lt_idle;
        res_fill_d = FILL_W'(count_r);
        state_d    = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= '0;
      time_q      <= '0;
      cur_slot_q  <= '0;
      cur_valid_q <= 1'b0;
      have_free_q <= 1'b0;
      have_old_q  <= 1'b0;
      new_q       <= 1'b0;
      popped_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      time_q      <= time_d;
      cur_slot_q  <= cur_slot_d;
      cur_valid_q <= cur_valid_d;
      have_free_q <= have_free_d;
      have_old_q  <= have_old_d;
      new_q       <= new_d;
      popped_q    <= popped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wid_q      <= wid_d;
    hgate_q    <= hgate_d;
    smp_q      <= smp_d;
    free_idx_q <= free_idx_d;
    old_idx_q  <= old_idx_d;
    old_last_q <= old_last_d;
    res_acc_q  <= res_acc_d;
    res_slot_q <= res_slot_d;
    res_drop_q <= res_drop_d;
    res_rvld_q <= res_rvld_d;
    res_smp_q  <= res_smp_d;
    res_use_q  <= res_use_d;
    res_gate_q <= res_gate_d;
    res_fill_q <= res_fill_d;
    if (out_load) begin
      out_acc_q  <= res_acc_q;
      out_slot_q <= res_slot_q;
      out_drop_q <= res_drop_q;
      out_rvld_q <= res_rvld_q;
      out_smp_q  <= res_smp_q;
      out_use_q  <= res_use_q;
      out_gate_q <= res_gate_q;
      out_fill_q <= res_fill_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q <= '0;
      gate_q  <= '0;
      for (int i = 0; i < VOICES; i++) begin
        id_q[i]    <= '0;
        last_q[i]  <= '0;
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < VOICES; i++) begin
        if (sel_q == SW'(i)) begin
          if (bind_we) begin
            bound_q[i] <= 1'b1;
            id_q[i]    <= wid_q;
            gate_q[i]  <= hgate_q;
            last_q[i]  <= time_q;
            if (new_q) begin
              head_q[i]  <= '0;
              count_q[i] <= '0;
            end
          end
          if (ring_we) begin
            head_q[i]  <= head_d;
            count_q[i] <= count_d;
          end
        end
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.accepted       = out_acc_q;
  assign out_o.slot           = out_slot_q;
  assign out_o.dropped_oldest = out_drop_q;
  assign out_o.read_valid     = out_rvld_q;
  assign out_o.read_sample    = out_smp_q;
  assign out_o.in_use         = out_use_q;
  assign out_o.gate_active    = out_gate_q;
  assign out_o.fill           = out_fill_q;

endmodule
